>>> rtl/windowed_mode_select_top_assert.svh
// windowed_mode_select_top_assert.svh
// Assertion helpers shared by the windowed mode select modules.
// Each macro expects clk and arst_n in scope.
`ifndef WINDOWED_MODE_SELECT_TOP_ASSERT_SVH
`define WINDOWED_MODE_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define WMS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wms assertion failed");

// Next-cycle implication, checked out of reset
`define WMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wms assertion failed");

`endif

>>> rtl/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared constants, tie rule codes and controller/datapath interface types
// for the windowed mode select block.
// ----------------------------------------------------------------------------
package wms_pkg;

	// Default window depth
	localparam int MAX_WINDOW_DEF = 32;

	// Sample and tie rule widths
	localparam int VALUE_W = 32;
	localparam int TIE_W   = 3;

	// Tie rule codes; codes above TIE_NONE behave as TIE_NONE
	localparam logic [TIE_W-1:0] TIE_LOW    = 3'd0;
	localparam logic [TIE_W-1:0] TIE_HIGH   = 3'd1;
	localparam logic [TIE_W-1:0] TIE_FIRST  = 3'd2;
	localparam logic [TIE_W-1:0] TIE_RANDOM = 3'd3;
	localparam logic [TIE_W-1:0] TIE_NONE   = 3'd4;

	// Galois LFSR for random tie breaking
	localparam int               LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;   // accept one sample word into the table
		logic scan;   // examine one table entry in the max search
		logic emit;   // load the result register and clear the window
	} wms_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_last;  // current scan entry is the last one in use
	} wms_sts_t;

endpackage

>>> rtl/wms_ctrl.sv
// ----------------------------------------------------------------------------
// wms_ctrl
// Window controller: accumulates samples, steps the max search over the
// table, and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module wms_ctrl
	import wms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last_sample,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  wms_sts_t sts,
	output wms_cmd_t cmd
);

`include "windowed_mode_select_top_assert.svh"

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Take sample words only while accumulating
	assign in_stall  = (state_q != ST_ACCUM);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decode commands
	always_comb begin
		cmd.take = 1'b0;
		cmd.scan = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_ACCUM: cmd.take = in_valid;
			ST_SCAN:  cmd.scan = 1'b1;
			ST_DONE:  cmd.emit = out_free;
			default:  cmd.take = 1'b0;
		endcase
	end

	// Advance state and hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ACCUM: begin
					if (in_valid && last_sample) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_ACCUM;
				end
				default: state_q <= ST_ACCUM;
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`WMS_ASSERT_NEXT(a_scan_to_done, (state_q == ST_SCAN) && sts.scan_last, state_q == ST_DONE)
	`WMS_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_valid_q)
	`WMS_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.take, cmd.scan, cmd.emit}))

endmodule

>>> rtl/wms_dp.sv
// ----------------------------------------------------------------------------
// wms_dp
// Datapath: distinct value table with per-entry counts, sequential max
// search with tie rules, LFSR, tie rule register and result register.
// ----------------------------------------------------------------------------
module wms_dp
	import wms_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wms_cmd_t                  cmd,
	output wms_sts_t                  sts,
	input  logic                      cfg_we,
	input  logic [TIE_W-1:0]          cfg_wdata,
	input  logic signed [VALUE_W-1:0] sample_value,
	output logic signed [VALUE_W-1:0] mode_value,
	output logic                      no_mode,
	output logic                      window_overflow
);

`include "windowed_mode_select_top_assert.svh"

	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int PROD_W = LFSR_W + CNT_W;

	// Table storage
	logic signed [VALUE_W-1:0] vals_q [MAX_WINDOW];
	logic [CNT_W-1:0]          cnts_q [MAX_WINDOW];

	// Window control state
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  items_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [TIE_W-1:0]  tie_mode_q;

	// Search registers
	logic signed [VALUE_W-1:0] best_val_q;
	logic [CNT_W-1:0]          best_cnt_q;
	logic [CNT_W-1:0]          ties_q;

	// Result register
	logic signed [VALUE_W-1:0] mode_value_q;
	logic                      no_mode_q;
	logic                      ovf_out_q;

	// Sample path
	logic [MAX_WINDOW-1:0] match;
	logic                  hit;
	logic                  full;
	logic                  take_new;

	// Scan path
	logic signed [VALUE_W-1:0] entry_val;
	logic [CNT_W-1:0]          entry_cnt;
	logic                      first;
	logic                      gt;
	logic                      eq;
	logic [CNT_W-1:0]          ties_inc;
	logic [LFSR_W-1:0]         lfsr_adv;
	logic [PROD_W-1:0]         prod;
	logic                      pick_rand;
	logic                      tie_none;

	// Compare the sample word against every entry in use
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			match[i] = (CNT_W'(i) < used_q) && (vals_q[i] == sample_value);
		end
	end

	assign hit      = |match;
	assign full     = (items_q == CNT_W'(MAX_WINDOW));
	assign take_new = cmd.take && !full && !hit;

	// Read the entry under the scan index
	assign entry_val = vals_q[idx_q];
	assign entry_cnt = cnts_q[idx_q];
	assign first     = (idx_q == '0);
	assign gt        = entry_cnt > best_cnt_q;
	assign eq        = entry_cnt == best_cnt_q;
	assign ties_inc  = ties_q + CNT_W'(1);
	assign lfsr_adv  = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
	assign prod      = PROD_W'(lfsr_adv) * PROD_W'(ties_inc);
	assign pick_rand = (prod[PROD_W-1:LFSR_W] == '0);
	assign tie_none  = (tie_mode_q >= TIE_NONE);

	assign sts.scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);

	// Update the table: bump a matching count or append a new entry
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (take_new && (CNT_W'(i) == used_q)) begin
				vals_q[i] <= sample_value;
				cnts_q[i] <= CNT_W'(1);
			end else if (cmd.take && !full && match[i]) begin
				cnts_q[i] <= cnts_q[i] + CNT_W'(1);
			end
		end
	end

	// Hold window counters, scan index, LFSR and tie rule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			items_q    <= '0;
			ovf_q      <= 1'b0;
			idx_q      <= '0;
			lfsr_q     <= LFSR_SEED;
			tie_mode_q <= TIE_LOW;
		end else begin
			if (cfg_we) tie_mode_q <= cfg_wdata;
			if (cmd.take) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					items_q <= items_q + CNT_W'(1);
					if (!hit) used_q <= used_q + CNT_W'(1);
				end
			end
			if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
				if (!first && !gt && eq && (tie_mode_q == TIE_RANDOM)) lfsr_q <= lfsr_adv;
			end
			if (cmd.emit) begin
				used_q  <= '0;
				items_q <= '0;
				ovf_q   <= 1'b0;
				idx_q   <= '0;
			end
		end
	end

	// Step the max search by one entry
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			priority if (first || gt) begin
				best_val_q <= entry_val;
				best_cnt_q <= entry_cnt;
				ties_q     <= CNT_W'(1);
			end else if (eq) begin
				ties_q <= ties_inc;
				unique case (tie_mode_q)
					TIE_LOW:    if (entry_val < best_val_q) best_val_q <= entry_val;
					TIE_HIGH:   if (best_val_q < entry_val) best_val_q <= entry_val;
					TIE_RANDOM: if (pick_rand) best_val_q <= entry_val;
					default:    best_val_q <= best_val_q;
				endcase
			end else begin
				// lower count: hold the current pick
				ties_q <= ties_q;
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (tie_none && (ties_q > CNT_W'(1))) begin
				mode_value_q <= '0;
				no_mode_q    <= 1'b1;
			end else begin
				mode_value_q <= best_val_q;
				no_mode_q    <= 1'b0;
			end
			ovf_out_q <= ovf_q;
		end
	end

	assign mode_value      = mode_value_q;
	assign no_mode         = no_mode_q;
	assign window_overflow = ovf_out_q;

	`WMS_ASSERT_NOW(a_scan_in_range, cmd.scan, CNT_W'(idx_q) < used_q)
	`WMS_ASSERT_NOW(a_table_bounds, 1'b1,
		(items_q <= CNT_W'(MAX_WINDOW)) && (used_q <= items_q))

endmodule

>>> rtl/windowed_mode_select_top.sv
// ----------------------------------------------------------------------------
// windowed_mode_select_top
// Modal value of a window of signed samples with selectable tie rule.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one sample word per cycle when
//   in_stall is low: sample_value and last_sample, which closes the window.
//   Up to MAX_WINDOW samples count; later ones drop and set window_overflow.
//   Output channel (out_valid/out_stall) carries one result word per window:
//   mode_value, no_mode, window_overflow.
//   Throughput: one sample per cycle while a window fills.
//   After the closing sample, the max search reads one table entry a cycle,
//   one per distinct value in the window, and in_stall stays high until the
//   result has been loaded into the output register.
//   The result sits in an output register, so the next window fills while it
//   waits; a stalled receiver only holds off the end of the following window.
//   tie_mode is written with cfg_we/cfg_wdata while the block is idle; the
//   user must keep to this, as the block does not enforce it. Reset clears
//   the window, sets tie_mode to 0 and seeds the LFSR, which carries over.
// ----------------------------------------------------------------------------
module windowed_mode_select_top
	import wms_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [TIE_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] sample_value,
	input  logic                      last_sample,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] mode_value,
	output logic                      no_mode,
	output logic                      window_overflow
);

	wms_cmd_t cmd;
	wms_sts_t sts;

	// Sequence the window
	wms_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Count values and pick the mode
	wms_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.sample_value    (sample_value),
		.mode_value      (mode_value),
		.no_mode         (no_mode),
		.window_overflow (window_overflow)
	);

endmodule
